[hw/rtl/square_matrix_multiply_unit_defines.svh]
// Assertion macros for the square matrix multiply unit.
// Used by the port checker; no other dependencies.
`ifndef SQUARE_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define SQUARE_MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define SMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/smm_pkg.sv]
// Shared types and constants for the square matrix multiply unit.
// No dependencies; imported by every module of the block.
package smm_pkg;

    localparam int MAX_DIM_DEF    = 64;
    localparam int ELEM_WIDTH_DEF = 16;

    localparam int OP_W   = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 38;
    localparam int SIZE_W = 7;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_ROW    = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    // Control tag that travels down the MAC pipeline with each read pair
    typedef struct packed {
        logic valid;
        logic first;
        logic last_k;
        logic last_col;
    } t_tag;

endpackage

[hw/rtl/smm_stream_if.sv]
// Valid/ready channel interfaces for the square matrix multiply unit.
// Depends on smm_pkg for field widths.
interface smm_in_if import smm_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, op, row, col, value, input ready);
    modport sink   (input valid, op, row, col, value, output ready);
endinterface

interface smm_out_if import smm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [ROW_W-1:0]         out_row;
    logic [COL_W-1:0]         out_col;
    logic signed [PROD_W-1:0] product;
    logic                     last;

    modport source (output valid, out_row, out_col, product, last, input ready);
    modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

[hw/rtl/square_matrix_multiply_unit.sv]
// Load transfers are taken whenever the unit is idle. A row request with size n (active rows and columns)
// issues n*n read pairs to the single MAC, one per cycle unless the output stalls; the row's
// n results leave in column order, and no new item is taken until the last read pair has
// been issued, set by the one read port per store and the one MAC.
// Synchronous active-low reset: size register to 64, pipeline empty; the element
// stores are not cleared and hold undefined data until written.
module square_matrix_multiply_unit
    import smm_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    smm_in_if.sink            i_in,
    smm_out_if.source         o_out
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);

    logic                         w_adv;
    logic                         w_we_a;
    logic                         w_we_b;
    logic [AW-1:0]                w_waddr;
    logic signed [ELEM_WIDTH-1:0] w_wdata;
    logic                         w_rd_en;
    logic [AW-1:0]                w_raddr_a;
    logic [AW-1:0]                w_raddr_b;
    logic signed [ELEM_WIDTH-1:0] w_rdata_a;
    logic signed [ELEM_WIDTH-1:0] w_rdata_b;
    t_tag                         w_tag;
    logic [ROW_W-1:0]             w_row;
    logic [IDX_W-1:0]             w_col;

    smm_seq #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_adv       (w_adv),
        .o_we_a      (w_we_a),
        .o_we_b      (w_we_b),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_rd_en     (w_rd_en),
        .o_raddr_a   (w_raddr_a),
        .o_raddr_b   (w_raddr_b),
        .o_tag       (w_tag),
        .o_row       (w_row),
        .o_col       (w_col)
    );

    smm_store #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we_a    (w_we_a),
        .i_we_b    (w_we_b),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_rd_en   (w_rd_en),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    smm_mac #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_row   (w_row),
        .i_col   (w_col),
        .i_a     (w_rdata_a),
        .i_b     (w_rdata_b),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

endmodule

[hw/rtl/smm_store.sv]
// Element stores for A and B: one write port and one registered read port each.
// Depends on smm_pkg.
module smm_store
    import smm_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we_a,
    input  logic                         i_we_b,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] i_waddr,
    input  logic signed [ELEM_WIDTH-1:0] i_wdata,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] i_raddr_a,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] i_raddr_b,
    output logic signed [ELEM_WIDTH-1:0] o_rdata_a,
    output logic signed [ELEM_WIDTH-1:0] o_rdata_b
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic signed [ELEM_WIDTH-1:0] r_mem_a [DEPTH];
    logic signed [ELEM_WIDTH-1:0] r_mem_b [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we_a) begin
            r_mem_a[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            o_rdata_a <= r_mem_a[i_raddr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we_b) begin
            r_mem_b[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            o_rdata_b <= r_mem_b[i_raddr_b];
        end
    end

endmodule

[hw/rtl/smm_seq.sv]
// Input handling, size register and read-address sequencer.
// Depends on smm_pkg and smm_stream_if.
module smm_seq
    import smm_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [SIZE_W-1:0]            i_cfg_wdata,
    smm_in_if.sink                       i_in,
    input  logic                         i_adv,
    output logic                         o_we_a,
    output logic                         o_we_b,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_waddr,
    output logic signed [ELEM_WIDTH-1:0] o_wdata,
    output logic                         o_rd_en,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_raddr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_raddr_b,
    output t_tag                         o_tag,
    output logic [ROW_W-1:0]             o_row,
    output logic [$clog2(MAX_DIM)-1:0]   o_col
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int SZ_W  = $clog2(MAX_DIM + 1);
    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_size;
    logic [SZ_W-1:0]    r_n;
    logic [SZ_W-1:0]    w_active;
    logic [ROW_W-1:0]   r_row;
    logic [IDX_W-1:0]   r_j;
    logic [IDX_W-1:0]   r_k;
    logic               w_accept;
    logic               w_load_ok;
    logic               w_row_ok;
    logic               w_issue;
    logic               w_last_k;
    logic               w_last_j;

    // size 0 behaves as 1, anything above the store as the store size
    always_comb begin
        if (r_size == '0) begin
            w_active = SZ_W'(1);
        end else if (32'(r_size) > MAX_DIM) begin
            w_active = SZ_W'(MAX_DIM);
        end else begin
            w_active = SZ_W'(r_size);
        end
    end

    assign w_accept  = i_in.valid && i_in.ready;
    assign w_load_ok = (32'(i_in.row) < MAX_DIM) && (32'(i_in.col) < MAX_DIM);
    assign w_row_ok  = 32'(i_in.row) < 32'(w_active);
    assign w_last_k  = 32'(r_k) == 32'(r_n) - 32'd1;
    assign w_last_j  = 32'(r_j) == 32'(r_n) - 32'd1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_in.op == OP_ROW && w_row_ok) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_adv && w_last_k && w_last_j) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        w_issue    = 1'b0;
        case (r_state)
            S_IDLE:  i_in.ready = 1'b1;
            S_RUN:   w_issue    = i_adv;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= SIZE_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
        end
    end

    // k runs inner (dot product), j outer (column of the result row)
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row <= i_in.row;
            r_n   <= w_active;
            r_j   <= '0;
            r_k   <= '0;
        end else if (w_issue) begin
            if (w_last_k) begin
                r_k <= '0;
                r_j <= r_j + IDX_W'(1);
            end else begin
                r_k <= r_k + IDX_W'(1);
            end
        end
    end

    assign o_we_a  = w_accept && i_in.op == OP_LOAD_A && w_load_ok;
    assign o_we_b  = w_accept && i_in.op == OP_LOAD_B && w_load_ok;
    assign o_waddr = AW'(i_in.row) * AW'(MAX_DIM) + AW'(i_in.col);
    assign o_wdata = ELEM_WIDTH'(32'(i_in.value));

    assign o_rd_en   = i_adv;
    assign o_raddr_a = AW'(r_row) * AW'(MAX_DIM) + AW'(r_k);
    assign o_raddr_b = AW'(r_k) * AW'(MAX_DIM) + AW'(r_j);

    assign o_tag.valid    = w_issue;
    assign o_tag.first    = r_k == '0;
    assign o_tag.last_k   = w_last_k;
    assign o_tag.last_col = w_last_j;
    assign o_row          = r_row;
    assign o_col          = r_j;

endmodule

[hw/rtl/smm_mac.sv]
// Shared multiply-accumulate pipeline and output register.
// Depends on smm_pkg and smm_stream_if.
module smm_mac
    import smm_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_tag                         i_tag,
    input  logic [ROW_W-1:0]             i_row,
    input  logic [$clog2(MAX_DIM)-1:0]   i_col,
    input  logic signed [ELEM_WIDTH-1:0] i_a,
    input  logic signed [ELEM_WIDTH-1:0] i_b,
    output logic                         o_adv,
    smm_out_if.source                    o_out
);

    localparam int IDX_W = $clog2(MAX_DIM);

    t_tag                           r_s1_tag, r_s2_tag;
    logic [ROW_W-1:0]               r_s1_row, r_s2_row;
    logic [IDX_W-1:0]               r_s1_col, r_s2_col;
    logic signed [2*ELEM_WIDTH-1:0] r_prod;
    logic signed [PROD_W-1:0]       r_acc;
    logic signed [PROD_W-1:0]       w_sum;
    logic                           w_done;
    logic                           r_out_valid;
    logic [ROW_W-1:0]               r_out_row;
    logic [COL_W-1:0]               r_out_col;
    logic signed [PROD_W-1:0]       r_out_prod;
    logic                           r_out_last;

    // whole pipeline freezes only when a finished element meets a full output that is not ready
    assign w_done = r_s2_tag.valid && r_s2_tag.last_k;
    assign o_adv  = !(w_done && r_out_valid && !o_out.ready);
    assign w_sum  = (r_s2_tag.first ? PROD_W'(0) : r_acc) + PROD_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag    <= '0;
            r_s2_tag    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_s1_tag <= i_tag;
                r_s2_tag <= r_s1_tag;
            end
            if (o_adv && w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s1_row <= i_row;
            r_s1_col <= i_col;
            r_s2_row <= r_s1_row;
            r_s2_col <= r_s1_col;
            r_prod   <= i_a * i_b;
        end
        if (o_adv && r_s2_tag.valid) begin
            r_acc <= w_sum;
        end
        if (o_adv && w_done) begin
            r_out_row  <= r_s2_row;
            r_out_col  <= COL_W'(r_s2_col);
            r_out_prod <= w_sum;
            r_out_last <= r_s2_tag.last_col;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.out_row = r_out_row;
    assign o_out.out_col = r_out_col;
    assign o_out.product = r_out_prod;
    assign o_out.last    = r_out_last;

endmodule

[hw/rtl/smm_checker.sv]
// Port-level checker for the square matrix multiply unit, bound to the top level.
// Depends on smm_pkg and square_matrix_multiply_unit_defines.svh.
`include "square_matrix_multiply_unit_defines.svh"

module smm_checker
    import smm_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic [OP_W-1:0]          i_in_op,
    input logic [ROW_W-1:0]         i_in_row,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [ROW_W-1:0]         i_out_row,
    input logic [COL_W-1:0]         i_out_col,
    input logic signed [PROD_W-1:0] i_out_product,
    input logic                     i_out_last
);

    logic             w_in_xfer;
    logic             w_out_xfer;
    logic [COL_W-1:0] r_exp_col;

    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;

    // every emitted row runs left to right from column zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_col <= '0;
        end else if (w_out_xfer) begin
            r_exp_col <= i_out_last ? '0 : i_out_col + COL_W'(1);
        end
    end

    `SMM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_out_row, i_out_col, i_out_product, i_out_last}), "stalled result changed")
    `SMM_ASSERT_NOW(a_col_order, i_clk, i_rst_n, w_out_xfer, i_out_col == r_exp_col, "result column out of order")
    `SMM_ASSERT_NEXT(a_row_busy, i_clk, i_rst_n, w_in_xfer && i_in_op == OP_ROW && i_in_row == '0, !i_in_ready, "row request did not start")
    `SMM_ASSERT_NEXT(a_load_quick, i_clk, i_rst_n, w_in_xfer && (i_in_op == OP_LOAD_A || i_in_op == OP_LOAD_B), i_in_ready, "load transfer held the input")

endmodule

bind square_matrix_multiply_unit smm_checker u_smm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_op       (i_in.op),
    .i_in_row      (i_in.row),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_row     (o_out.out_row),
    .i_out_col     (o_out.out_col),
    .i_out_product (o_out.product),
    .i_out_last    (o_out.last)
);
